### sv/polyphase_interpolating_fir_macros.svh
// ----------------------------------------------------------------------------
// polyphase interpolating fir assertion macros
// shared property templates for the filter checks
// ----------------------------------------------------------------------------
`ifndef POLYPHASE_INTERPOLATING_FIR_MACROS_SVH
`define POLYPHASE_INTERPOLATING_FIR_MACROS_SVH

// same-cycle implication
`define PIF_AST_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pif check failed");

// next-cycle implication
`define PIF_AST_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pif check failed");

`endif

### sv/pif_pkg.sv
// ----------------------------------------------------------------------------
// pif_pkg
// shared types, constants and rounding for the polyphase interpolating fir
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pif_pkg;

   localparam int MaxTaps   = 64;
   localparam int MaxFactor = 16;
   localparam int TapW      = 16;
   localparam int SmpW      = 16;
   localparam int AddrW     = $clog2(MaxTaps);
   localparam int AccW      = 2 * SmpW + AddrW;
   localparam int FactorW   = 5;
   localparam int CountW    = 7;
   localparam int BaseW     = 8;
   localparam int CsrIdxW   = 2;
   localparam int CsrDataW  = 7;

   typedef logic [1:0] func_type;
   localparam func_type FUNC_LOAD  = 2'd0;
   localparam func_type FUNC_PUSH  = 2'd1;
   localparam func_type FUNC_FLUSH = 2'd2;

   typedef logic [CsrIdxW-1:0] csr_idx_type;
   localparam csr_idx_type CSR_FACTOR = 2'd0;
   localparam csr_idx_type CSR_TAPS   = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_OUT,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic push;
      logic rot;
      logic clr;
   } cell_ctrl_type;

   function automatic logic signed [SmpW-1:0] round_sat(input logic signed [AccW-1:0] acc);
      logic signed [AccW:0] v;
      logic signed [AccW:0] q;
      v = {acc[AccW-1], acc} + (AccW+1)'(16384);
      q = v >>> 15;
      if (q > (AccW+1)'(32767)) begin
         round_sat = 16'sh7fff;
      end else if (q < -(AccW+1)'(32768)) begin
         round_sat = 16'sh8000;
      end else begin
         round_sat = q[SmpW-1:0];
      end
   endfunction

endpackage

### sv/pif_if.sv
// ----------------------------------------------------------------------------
// pif channel interfaces
// request, response and register-write channels with valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pif_req_if;
   logic                    valid;
   logic                    ready;
   pif_pkg::func_type       func;
   logic [5:0]              tap_index;
   logic signed [15:0]      tap_value;
   logic signed [15:0]      sample_re;
   logic signed [15:0]      sample_im;
   modport source (output valid, func, tap_index, tap_value, sample_re, sample_im,
                   input ready);
   modport sink (input valid, func, tap_index, tap_value, sample_re, sample_im,
                 output ready);
endinterface

interface pif_rsp_if;
   logic                    valid;
   logic                    ready;
   logic signed [15:0]      out_re;
   logic signed [15:0]      out_im;
   logic                    last;
   modport source (output valid, out_re, out_im, last, input ready);
   modport sink (input valid, out_re, out_im, last, output ready);
endinterface

interface pif_csr_if;
   logic                                valid;
   logic                                ready;
   pif_pkg::csr_idx_type                index;
   logic [pif_pkg::CsrDataW-1:0]        data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### sv/pif_cell.sv
// ----------------------------------------------------------------------------
// pif_cell
// one history entry: shifts on push, rotates during a sweep, clears on flush
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pif_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  pif_pkg::cell_ctrl_type              ctrl,
   input  logic signed [pif_pkg::SmpW-1:0]     push_re,
   input  logic signed [pif_pkg::SmpW-1:0]     push_im,
   input  logic signed [pif_pkg::SmpW-1:0]     rot_re,
   input  logic signed [pif_pkg::SmpW-1:0]     rot_im,
   output logic signed [pif_pkg::SmpW-1:0]     re,
   output logic signed [pif_pkg::SmpW-1:0]     im
);

   logic signed [pif_pkg::SmpW-1:0] re_ff, re_in;
   logic signed [pif_pkg::SmpW-1:0] im_ff, im_in;

   always_comb begin
      re_in = re_ff;
      im_in = im_ff;
      if (ctrl.clr) begin
         re_in = '0;
         im_in = '0;
      end else if (ctrl.push) begin
         re_in = push_re;
         im_in = push_im;
      end else if (ctrl.rot) begin
         re_in = rot_re;
         im_in = rot_im;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         re_ff <= '0;
         im_ff <= '0;
      end else begin
         re_ff <= re_in;
         im_ff <= im_in;
      end
   end

   assign re = re_ff;
   assign im = im_ff;

endmodule

### sv/pif_tap_ram.sv
// ----------------------------------------------------------------------------
// pif_tap_ram
// tap store, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pif_tap_ram (
   input  logic                                clock,
   input  logic                                we,
   input  logic [pif_pkg::AddrW-1:0]           waddr,
   input  logic signed [pif_pkg::TapW-1:0]     wdata,
   input  logic [pif_pkg::AddrW-1:0]           raddr,
   output logic signed [pif_pkg::TapW-1:0]     rdata
);

   logic signed [pif_pkg::TapW-1:0] mem_ff [pif_pkg::MaxTaps];
   logic signed [pif_pkg::TapW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/pif_mac.sv
// ----------------------------------------------------------------------------
// pif_mac
// complex-by-real multiply-accumulate with rounding and saturation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pif_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                issue,
   input  logic                                clr,
   input  logic signed [pif_pkg::SmpW-1:0]     hist_re,
   input  logic signed [pif_pkg::SmpW-1:0]     hist_im,
   input  logic signed [pif_pkg::TapW-1:0]     tap,
   output logic signed [pif_pkg::SmpW-1:0]     out_re,
   output logic signed [pif_pkg::SmpW-1:0]     out_im
);

   localparam int ProdW = pif_pkg::SmpW + pif_pkg::TapW;

   logic                              v1_ff, v1_in;
   logic                              v2_ff, v2_in;
   logic signed [pif_pkg::SmpW-1:0]   hre_ff, hre_in;
   logic signed [pif_pkg::SmpW-1:0]   him_ff, him_in;
   logic signed [ProdW-1:0]           pre_ff, pre_in;
   logic signed [ProdW-1:0]           pim_ff, pim_in;
   logic signed [pif_pkg::AccW-1:0]   acc_re_ff, acc_re_in;
   logic signed [pif_pkg::AccW-1:0]   acc_im_ff, acc_im_in;

   always_comb begin
      v1_in     = issue;
      hre_in    = hist_re;
      him_in    = hist_im;
      v2_in     = v1_ff;
      pre_in    = hre_ff * tap;
      pim_in    = him_ff * tap;
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (clr) begin
         acc_re_in = '0;
         acc_im_in = '0;
      end else if (v2_ff) begin
         acc_re_in = acc_re_ff + pif_pkg::AccW'(pre_ff);
         acc_im_in = acc_im_ff + pif_pkg::AccW'(pim_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else begin
         v1_ff     <= v1_in;
         v2_ff     <= v2_in;
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
      end
      hre_ff <= hre_in;
      him_ff <= him_in;
      pre_ff <= pre_in;
      pim_ff <= pim_in;
   end

   assign out_re = pif_pkg::round_sat(acc_re_ff);
   assign out_im = pif_pkg::round_sat(acc_im_ff);

endmodule

### sv/polyphase_interpolating_fir.sv
// each output sample is a sweep of the history ring past one mac, a drain of the mac
// pipeline and a load of the output register, which waits while a held response is unread
// a push item yields upsample_factor outputs, a flush item tap_count - 1 outputs and then
// a clear of the history ring; loads write the tap store; csr writes are never stalled
// synchronous reset clears the history ring and sets upsample_factor and tap_count to 1
// ----------------------------------------------------------------------------
// polyphase_interpolating_fir
// complex-sample interpolating fir with a rotating history ring and one mac
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "polyphase_interpolating_fir_macros.svh"

module polyphase_interpolating_fir (
   input  logic       clock,
   input  logic       reset,
   pif_req_if.sink    req,
   pif_rsp_if.source  rsp,
   pif_csr_if.sink    csr
);

   localparam int N = pif_pkg::MaxTaps;

   pif_pkg::state_type               state_ff, state_in;
   logic [pif_pkg::CountW-1:0]       cnt_ff, cnt_in;
   logic [pif_pkg::AddrW-1:0]        step_ff, step_in;
   logic [pif_pkg::BaseW-1:0]        t_ff, t_in;
   logic                             drain_ff, drain_in;
   logic                             flush_ff, flush_in;
   logic [pif_pkg::FactorW-1:0]      factor_ff, factor_in;
   logic [pif_pkg::CountW-1:0]       taps_ff, taps_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]               rsp_re_ff, rsp_re_in;
   logic signed [15:0]               rsp_im_ff, rsp_im_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic [pif_pkg::FactorW-1:0]      sps;
   logic [pif_pkg::CountW-1:0]       m;
   logic [pif_pkg::CountW-1:0]       n_total;
   logic [pif_pkg::CountW-1:0]       cnt_inc;
   logic                             req_acc;
   logic                             csr_acc;
   logic                             out_load;
   logic                             issue;
   logic                             acc_clr;
   pif_pkg::cell_ctrl_type           cell_ctrl;
   logic signed [15:0]               hist_re [N];
   logic signed [15:0]               hist_im [N];
   logic signed [15:0]               tap_rd;
   logic signed [15:0]               mac_re;
   logic signed [15:0]               mac_im;

   assign req_acc = req.valid && req.ready;
   assign csr_acc = csr.valid && csr.ready;
   assign csr.ready = 1'b1;

   always_comb begin
      if (factor_ff == '0) begin
         sps = pif_pkg::FactorW'(1);
      end else if (factor_ff > pif_pkg::FactorW'(pif_pkg::MaxFactor)) begin
         sps = pif_pkg::FactorW'(pif_pkg::MaxFactor);
      end else begin
         sps = factor_ff;
      end
      if (taps_ff == '0) begin
         m = pif_pkg::CountW'(1);
      end else if (taps_ff > pif_pkg::CountW'(pif_pkg::MaxTaps)) begin
         m = pif_pkg::CountW'(pif_pkg::MaxTaps);
      end else begin
         m = taps_ff;
      end
      n_total = flush_ff ? m - pif_pkg::CountW'(1) : pif_pkg::CountW'(sps);
      cnt_inc = cnt_ff + pif_pkg::CountW'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pif_pkg::ST_IDLE: begin
            if (req_acc && req.func == pif_pkg::FUNC_PUSH) begin
               state_in = pif_pkg::ST_RUN;
            end else if (req_acc && req.func == pif_pkg::FUNC_FLUSH) begin
               state_in = (m == pif_pkg::CountW'(1)) ? pif_pkg::ST_CLEAR : pif_pkg::ST_RUN;
            end
         end
         pif_pkg::ST_RUN: begin
            if (step_ff == pif_pkg::AddrW'(N - 1)) begin
               state_in = pif_pkg::ST_DRAIN;
            end
         end
         pif_pkg::ST_DRAIN: begin
            if (drain_ff) begin
               state_in = pif_pkg::ST_OUT;
            end
         end
         pif_pkg::ST_OUT: begin
            if (out_load) begin
               if (cnt_inc == n_total) begin
                  state_in = flush_ff ? pif_pkg::ST_CLEAR : pif_pkg::ST_IDLE;
               end else begin
                  state_in = pif_pkg::ST_RUN;
               end
            end
         end
         pif_pkg::ST_CLEAR: state_in = pif_pkg::ST_IDLE;
         default: state_in = pif_pkg::ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req.ready     = 1'b0;
      cell_ctrl     = '0;
      issue         = 1'b0;
      out_load      = 1'b0;
      acc_clr       = 1'b0;
      case (state_ff)
         pif_pkg::ST_IDLE: begin
            req.ready      = 1'b1;
            cell_ctrl.push = req_acc && req.func == pif_pkg::FUNC_PUSH;
            acc_clr        = 1'b1;
         end
         pif_pkg::ST_RUN: begin
            cell_ctrl.rot = 1'b1;
            issue         = t_ff < {1'b0, m};
         end
         pif_pkg::ST_DRAIN: begin
         end
         pif_pkg::ST_OUT: begin
            out_load = !rsp_valid_ff || rsp.ready;
            acc_clr  = out_load;
         end
         pif_pkg::ST_CLEAR: begin
            cell_ctrl.clr = 1'b1;
            acc_clr       = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // datapath registers
   always_comb begin
      cnt_in    = cnt_ff;
      flush_in  = flush_ff;
      step_in   = '0;
      drain_in  = 1'b0;
      t_in      = t_ff;
      factor_in = factor_ff;
      taps_in   = taps_ff;
      if (state_ff == pif_pkg::ST_IDLE && req_acc) begin
         cnt_in   = '0;
         flush_in = req.func == pif_pkg::FUNC_FLUSH;
      end else if (out_load) begin
         cnt_in = cnt_inc;
      end
      if (state_ff == pif_pkg::ST_RUN) begin
         step_in = step_ff + pif_pkg::AddrW'(1);
         if (issue) begin
            t_in = t_ff + pif_pkg::BaseW'(sps);
         end
      end else begin
         t_in = flush_in ? pif_pkg::BaseW'(sps) + pif_pkg::BaseW'(cnt_in)
                         : pif_pkg::BaseW'(cnt_in);
      end
      if (state_ff == pif_pkg::ST_DRAIN) begin
         drain_in = !drain_ff;
      end
      if (csr_acc && csr.index == pif_pkg::CSR_FACTOR) begin
         factor_in = csr.data[pif_pkg::FactorW-1:0];
      end
      if (csr_acc && csr.index == pif_pkg::CSR_TAPS) begin
         taps_in = csr.data;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_re_in    = rsp_re_ff;
      rsp_im_in    = rsp_im_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_re_in    = mac_re;
         rsp_im_in    = mac_im;
         rsp_last_in  = flush_ff && cnt_inc == n_total;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pif_pkg::ST_IDLE;
         cnt_ff       <= '0;
         step_ff      <= '0;
         drain_ff     <= 1'b0;
         flush_ff     <= 1'b0;
         factor_ff    <= pif_pkg::FactorW'(1);
         taps_ff      <= pif_pkg::CountW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         drain_ff     <= drain_in;
         flush_ff     <= flush_in;
         factor_ff    <= factor_in;
         taps_ff      <= taps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      t_ff        <= t_in;
      rsp_re_ff   <= rsp_re_in;
      rsp_im_ff   <= rsp_im_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.out_re = rsp_re_ff;
   assign rsp.out_im = rsp_im_ff;
   assign rsp.last   = rsp_last_ff;

   // history ring, newest in cell 0
   for (genvar k = 0; k < N; k++) begin : g_cell
      localparam int Nxt = (k + 1) % N;
      logic signed [15:0] p_re, p_im;
      if (k == 0) begin : g_head
         assign p_re = req.sample_re;
         assign p_im = req.sample_im;
      end else begin : g_body
         assign p_re = hist_re[k-1];
         assign p_im = hist_im[k-1];
      end
      pif_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (cell_ctrl),
         .push_re (p_re),
         .push_im (p_im),
         .rot_re  (hist_re[Nxt]),
         .rot_im  (hist_im[Nxt]),
         .re      (hist_re[k]),
         .im      (hist_im[k])
      );
   end

   pif_tap_ram u_taps (
      .clock (clock),
      .we    (state_ff == pif_pkg::ST_IDLE && req_acc && req.func == pif_pkg::FUNC_LOAD),
      .waddr (req.tap_index),
      .wdata (req.tap_value),
      .raddr (t_ff[pif_pkg::AddrW-1:0]),
      .rdata (tap_rd)
   );

   pif_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .issue   (issue),
      .clr     (acc_clr),
      .hist_re (hist_re[0]),
      .hist_im (hist_im[0]),
      .tap     (tap_rd),
      .out_re  (mac_re),
      .out_im  (mac_im)
   );

   `PIF_AST_NXT(a_push_runs, clock, reset, req_acc && req.func == pif_pkg::FUNC_PUSH, state_ff == pif_pkg::ST_RUN)
   `PIF_AST_IMP(a_last_on_flush, clock, reset, out_load && rsp_last_in, flush_ff)
   `PIF_AST_NXT(a_clear_zero, clock, reset, state_ff == pif_pkg::ST_CLEAR, hist_re[0] == '0 && hist_im[N-1] == '0)

endmodule

### tb/polyphase_interpolating_fir_tb.sv
// ----------------------------------------------------------------------------
// polyphase_interpolating_fir_tb
// self-checking bench: loads taps, pushes and flushes complex symbols under
// several factor and tap-count settings with random stalls on both channels,
// and compares every output against a bit-exact filter model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polyphase_interpolating_fir_tb;

   localparam pif_pkg::func_type FUNC_NONE = 2'd3;
   localparam int                CycleLimit = 10000000;

   typedef struct {
      logic signed [15:0] re;
      logic signed [15:0] im;
      logic               last;
   } fir_output_type;

   class fir_scoreboard;
      logic signed [15:0] taps [pif_pkg::MaxTaps];
      logic signed [15:0] hist_re [pif_pkg::MaxTaps];
      logic signed [15:0] hist_im [pif_pkg::MaxTaps];
      logic [4:0]         factor_reg;
      logic [6:0]         count_reg;
      fir_output_type     pending_outputs [$];
      int                 errors;

      function new();
         foreach (taps[i]) begin
            taps[i] = '0;
            hist_re[i] = '0;
            hist_im[i] = '0;
         end
         factor_reg = 5'd1;
         count_reg = 7'd1;
         errors = 0;
      endfunction

      function void write_reg(pif_pkg::csr_idx_type idx,
                              logic [pif_pkg::CsrDataW-1:0] data);
         if (idx == pif_pkg::CSR_FACTOR) factor_reg = data[4:0];
         else if (idx == pif_pkg::CSR_TAPS) count_reg = data[6:0];
      endfunction

      function logic signed [15:0] round_saturate(longint acc);
         longint q;
         q = (acc + 16384) >>> 15;
         if (q > 32767) q = 32767;
         if (q < -32768) q = -32768;
         return q[15:0];
      endfunction

      function void add_output(int base, int stride, int m, logic last);
         fir_output_type o;
         longint ar, ai;
         int k, t;
         ar = 0;
         ai = 0;
         k = 0;
         t = base;
         while (t < m && k < pif_pkg::MaxTaps) begin
            ar += longint'(hist_re[k]) * longint'(taps[t]);
            ai += longint'(hist_im[k]) * longint'(taps[t]);
            k++;
            t += stride;
         end
         o.re = round_saturate(ar);
         o.im = round_saturate(ai);
         o.last = last;
         pending_outputs.push_back(o);
      endfunction

      function void note_item(pif_pkg::func_type f, logic [5:0] idx, logic signed [15:0] val,
                              logic signed [15:0] re, logic signed [15:0] im);
         int sps, m, fr, cr;
         fr = int'(factor_reg);
         cr = int'(count_reg);
         sps = (fr < 1) ? 1 : (fr > pif_pkg::MaxFactor) ? pif_pkg::MaxFactor : fr;
         m = (cr < 1) ? 1 : (cr > pif_pkg::MaxTaps) ? pif_pkg::MaxTaps : cr;
         case (f)
            pif_pkg::FUNC_LOAD: begin
               taps[idx] = val;
            end
            pif_pkg::FUNC_PUSH: begin
               for (int i = pif_pkg::MaxTaps - 1; i > 0; i--) begin
                  hist_re[i] = hist_re[i-1];
                  hist_im[i] = hist_im[i-1];
               end
               hist_re[0] = re;
               hist_im[0] = im;
               for (int p = 0; p < sps; p++) add_output(p, sps, m, 1'b0);
            end
            pif_pkg::FUNC_FLUSH: begin
               for (int t = 0; t + 1 < m; t++) add_output(sps + t, sps, m, t + 2 == m);
               foreach (hist_re[i]) begin
                  hist_re[i] = '0;
                  hist_im[i] = '0;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_output(logic signed [15:0] re, logic signed [15:0] im,
                                 logic last);
         fir_output_type e;
         if (pending_outputs.size() == 0) begin
            $error("unexpected output re=%0d im=%0d last=%0b", re, im, last);
            errors++;
            return;
         end
         e = pending_outputs.pop_front();
         if (re !== e.re) begin
            $error("out_re expected %0d actual %0d", e.re, re);
            errors++;
         end
         if (im !== e.im) begin
            $error("out_im expected %0d actual %0d", e.im, im);
            errors++;
         end
         if (last !== e.last) begin
            $error("last expected %0b actual %0b", e.last, last);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic tx_gaps;
   logic rx_gaps;
   logic hold_off;
   int   cycle_count;
   fir_scoreboard sb;

   pif_req_if req_ch();
   pif_rsp_if rsp_ch();
   pif_csr_if csr_ch();

   polyphase_interpolating_fir dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("[polyphase_interpolating_fir] ERROR");
         $finish;
      end
   end

   // output side: random stalls and one long hold-off
   initial begin
      int stall_left;
      int hold_left;
      bit hold_used;
      stall_left = 0;
      hold_left = 0;
      hold_used = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            sb.check_output(rsp_ch.out_re, rsp_ch.out_im, rsp_ch.last);
         if (hold_off && !hold_used) begin
            hold_left = 400;
            hold_used = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_item(pif_pkg::func_type f, logic [5:0] idx, logic signed [15:0] val,
                            logic signed [15:0] re, logic signed [15:0] im);
      if (tx_gaps && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func <= f;
      req_ch.tap_index <= idx;
      req_ch.tap_value <= val;
      req_ch.sample_re <= re;
      req_ch.sample_im <= im;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_item(f, idx, val, re, im);
   endtask

   task automatic send_random_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 62)
         send_item(pif_pkg::FUNC_PUSH, 6'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
      else if (r < 77)
         send_item(pif_pkg::FUNC_LOAD, 6'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
      else if (r < 87)
         send_item(pif_pkg::FUNC_FLUSH, 6'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
      else if (r < 92)
         send_item(FUNC_NONE, 6'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
      else
         send_item(pif_pkg::FUNC_PUSH, 6'($urandom), 16'($urandom),
                   $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000,
                   $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
   endtask

   task automatic csr_write(pif_pkg::csr_idx_type idx, logic [pif_pkg::CsrDataW-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= data;
      do @(posedge clock); while (!csr_ch.ready);
      sb.write_reg(idx, data);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (sb.pending_outputs.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   initial begin
      int factors [8];
      int counts [8];
      factors = '{4, 16, 1, 8, 0, 2, 25, 3};
      counts = '{16, 64, 64, 33, 1, 5, 100, 0};
      sb = new();
      cycle_count = 0;
      tx_gaps = 1'b0;
      rx_gaps = 1'b0;
      hold_off = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.func = pif_pkg::FUNC_LOAD;
      req_ch.tap_index = '0;
      req_ch.tap_value = '0;
      req_ch.sample_re = '0;
      req_ch.sample_im = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = pif_pkg::CSR_FACTOR;
      csr_ch.data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // every tap is written before any read
      for (int i = 0; i < pif_pkg::MaxTaps; i++)
         send_item(pif_pkg::FUNC_LOAD, 6'(i),
                   (i == 0) ? 16'sh8000 : (i == 1) ? 16'sh7fff : 16'($urandom),
                   16'($urandom), 16'($urandom));

      // directed with a single tap and one phase, then with 64 taps and 16 phases
      send_item(pif_pkg::FUNC_FLUSH, '0, '0, '0, '0);
      send_item(pif_pkg::FUNC_PUSH, '0, '0, 16'sh8000, 16'sh8000);
      send_item(pif_pkg::FUNC_PUSH, '0, '0, 16'sh7fff, 16'sh8000);
      send_item(FUNC_NONE, 6'h3f, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_item(pif_pkg::FUNC_FLUSH, '0, '0, '0, '0);
      wait_idle();
      csr_write(pif_pkg::CSR_FACTOR, 7'd16);
      csr_write(pif_pkg::CSR_TAPS, 7'd64);
      csr_ch.valid <= 1'b0;
      send_item(pif_pkg::FUNC_FLUSH, '0, '0, '0, '0);
      send_item(pif_pkg::FUNC_PUSH, '0, '0, 16'sh7fff, 16'sh7fff);
      send_item(pif_pkg::FUNC_PUSH, '0, '0, 16'sh8000, 16'sh0001);
      send_item(pif_pkg::FUNC_LOAD, 6'd63, 16'sh8000, '0, '0);
      send_item(pif_pkg::FUNC_PUSH, '0, '0, 16'sh0000, 16'shffff);
      send_item(pif_pkg::FUNC_FLUSH, '0, '0, '0, '0);

      tx_gaps = 1'b1;
      rx_gaps = 1'b1;
      foreach (factors[ph]) begin
         wait_idle();
         csr_write(pif_pkg::CSR_FACTOR, 7'(factors[ph]));
         csr_write(pif_pkg::CSR_TAPS, 7'(counts[ph]));
         csr_ch.valid <= 1'b0;
         if (ph == 6) begin
            tx_gaps = 1'b0;
            rx_gaps = 1'b0;
         end
         hold_off = (ph == 0);
         for (int n = 0; n < 24; n++) begin
            send_random_item();
         end
      end

      wait_idle();
      repeat (200) @(posedge clock);
      if (sb.errors == 0)
         $display("[polyphase_interpolating_fir] OK");
      else
         $display("[polyphase_interpolating_fir] ERROR");
      $finish;
   end

endmodule
